FILE: rtl/controller_slot_pairing_table_defines.svh
// Assertion macros shared by the controller slot pairing table RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef CONTROLLER_SLOT_PAIRING_TABLE_DEFINES_SVH
`define CONTROLLER_SLOT_PAIRING_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cspt_pkg.sv
// Shared types and constants of the controller slot pairing table.
// Used by cspt_ctrl, cspt_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package cspt_pkg;

  localparam int unsigned MaxSlots       = 8;
  localparam int unsigned MaxControllers = 16;
  localparam int unsigned SlotW          = 4;
  localparam int unsigned CtrlW          = $clog2(MaxControllers);
  localparam int unsigned SlotIdxW       = $clog2(MaxSlots);
  localparam int unsigned CfgAddrW       = 3;
  localparam int unsigned CfgDataW       = 32;
  localparam int unsigned InDataW        = 16;
  localparam int unsigned OutDataW       = 24;

  localparam logic [SlotW-1:0]    SlotCountReset = SlotW'(4);
  localparam logic [CfgAddrW-1:0] AddrSlotCount  = CfgAddrW'(0);

  typedef enum logic [2:0] {
    REQ_PAIR      = 3'd0,
    REQ_UNPAIR    = 3'd1,
    REQ_SWAP      = 3'd2,
    REQ_ARRIVAL   = 3'd3,
    REQ_DEPARTURE = 3'd4,
    REQ_LOOKUP    = 3'd5
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_WRITE_A,
    ST_WRITE_B,
    ST_RESP
  } state_e;

  // Request item, last field in the lowest bits
  typedef struct packed {
    logic [SlotW-1:0] slot_b;
    logic [SlotW-1:0] slot_a;
    logic [CtrlW-1:0] ctrl_id;
    req_type_e        req_type;
  } req_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [MaxControllers-1:0] unpaired_mask;
    logic [SlotW-1:0]          found_slot;
    logic                      found;
    logic                      status;
  } res_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load_req;
    logic rd_a;
    logic rd_b;
    logic wr_a;
    logic wr_b;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic reject;
    logic is_swap;
    logic has_write;
    logic two_writes;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/controller_slot_pairing_table.sv
// Top level of the controller slot pairing table: stream ports, APB register.
// Instantiates cspt_ctrl and cspt_dp; uses cspt_pkg.
`timescale 1ns / 1ps
`include "controller_slot_pairing_table_defines.svh"

// Keeps the pairing between physical controllers 0..15 and virtual slots
// 1..slot_count (at most 8), with a connected flag per slot and a mask of
// unpaired controllers. One request is taken at a time and answers with one
// result. With one write per table per cycle, lookup and rejected requests
// pass read A and response; others add write A, pair also write B, and swap
// read B and write B. The port takes the next request in the cycle after
// the result is loaded, while it may still wait in the output register.
// slot_count sits at APB byte address 0 (reset 4); the user must write it
// only while the block is idle, and the block itself does not enforce this.
module controller_slot_pairing_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] req_type, [6:3] ctrl_id, [10:7] slot_a, [14:11] slot_b
  input  logic [cspt_pkg::InDataW-1:0]     s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] status, [1] found, [5:2] found_slot, [21:6] unpaired_mask
  output logic [cspt_pkg::OutDataW-1:0]    m_axis_tdata,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cspt_pkg::CfgAddrW-1:0]    paddr,
  input  logic [cspt_pkg::CfgDataW-1:0]    pwdata,
  output logic [cspt_pkg::CfgDataW-1:0]    prdata,
  output logic                             pready
);

  logic [cspt_pkg::SlotW-1:0] slot_count_q;
  cspt_pkg::cmd_t             cmd;
  cspt_pkg::sts_t             sts;
  cspt_pkg::req_t             req;
  cspt_pkg::res_t             res;
  logic                       cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == cspt_pkg::AddrSlotCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= cspt_pkg::SlotCountReset;
    end else if (cfg_wr) begin
      slot_count_q <= pwdata[cspt_pkg::SlotW-1:0];
    end
  end

  assign prdata = (paddr == cspt_pkg::AddrSlotCount) ?
                  cspt_pkg::CfgDataW'(slot_count_q) : '0;

  // Payload unpacking and packing
  assign req          = cspt_pkg::req_t'(s_axis_tdata[$bits(cspt_pkg::req_t)-1:0]);
  assign m_axis_tdata = cspt_pkg::OutDataW'(res);

  cspt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cspt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .slot_count_i (slot_count_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (res)
  );

  // One request in flight: the port closes right after an accept
  `CSPT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted twice")
  // A found lookup is accepted and names a real slot
  `CSPT_ASSERT_SAME(a_found_slot, m_axis_tvalid && res.found, !res.status && (res.found_slot != '0), "bad lookup result")

endmodule

FILE: rtl/cspt_ctrl.sv
// Request sequencer of the controller slot pairing table.
// Steps each request through read, optional write and response phases; uses cspt_pkg.
`timescale 1ns / 1ps
`include "controller_slot_pairing_table_defines.svh"

module cspt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cspt_pkg::sts_t  sts_i,
  output cspt_pkg::cmd_t  cmd_o
);

  cspt_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cspt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cspt_pkg::ST_READ_A;
      end
      cspt_pkg::ST_READ_A: begin
        if (sts_i.reject || !sts_i.has_write) begin
          state_d = cspt_pkg::ST_RESP;
        end else if (sts_i.is_swap) begin
          state_d = cspt_pkg::ST_READ_B;
        end else begin
          state_d = cspt_pkg::ST_WRITE_A;
        end
      end
      cspt_pkg::ST_READ_B:  state_d = cspt_pkg::ST_WRITE_A;
      cspt_pkg::ST_WRITE_A: begin
        state_d = sts_i.two_writes ? cspt_pkg::ST_WRITE_B : cspt_pkg::ST_RESP;
      end
      cspt_pkg::ST_WRITE_B: state_d = cspt_pkg::ST_RESP;
      cspt_pkg::ST_RESP: begin
        if (sts_i.out_free) state_d = cspt_pkg::ST_IDLE;
      end
      default: state_d = cspt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cspt_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_req  = in_valid_i;
      end
      cspt_pkg::ST_READ_A:  cmd_o.rd_a = 1'b1;
      cspt_pkg::ST_READ_B:  cmd_o.rd_b = 1'b1;
      cspt_pkg::ST_WRITE_A: cmd_o.wr_a = 1'b1;
      cspt_pkg::ST_WRITE_B: cmd_o.wr_b = 1'b1;
      cspt_pkg::ST_RESP:    cmd_o.load_out = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cspt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Second write phase only ever follows the first one
  `CSPT_ASSERT_SAME(a_wr_b_after_wr_a, cmd_o.wr_b, $past(cmd_o.wr_a), "wr_b without wr_a")

endmodule

FILE: rtl/cspt_dp.sv
// Datapath of the controller slot pairing table: slot and controller tables,
// unpaired set, request holding registers and result register; uses cspt_pkg.
`timescale 1ns / 1ps
`include "controller_slot_pairing_table_defines.svh"

module cspt_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cspt_pkg::req_t               req_i,
  input  logic [cspt_pkg::SlotW-1:0]   slot_count_i,
  input  cspt_pkg::cmd_t               cmd_i,
  output cspt_pkg::sts_t               sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output cspt_pkg::res_t               out_data_o
);

  localparam int unsigned NS = cspt_pkg::MaxSlots;
  localparam int unsigned NC = cspt_pkg::MaxControllers;
  localparam int unsigned SW = cspt_pkg::SlotW;
  localparam int unsigned CW = cspt_pkg::CtrlW;
  localparam int unsigned IW = cspt_pkg::SlotIdxW;

  // Slot number inside 1..min(slot_count, MaxSlots)
  function automatic logic slot_ok(input logic [SW-1:0] s, input logic [SW-1:0] cnt);
    logic [SW-1:0] live;
    live = (cnt < SW'(NS)) ? cnt : SW'(NS);
    return (s != '0) && (s <= live);
  endfunction

  // Tables
  logic          own_vld_q [NS];
  logic [CW-1:0] own_ctl_q [NS];
  logic          conn_q    [NS];
  logic [SW-1:0] home_q    [NC];
  logic [NC-1:0] unp_q, unp_d;

  // Held request and read-back values
  cspt_pkg::req_t req_q;
  logic [SW-1:0]  h_q;
  logic           oa_vld_q, ob_vld_q, ca_q, cb_q;
  logic [CW-1:0]  oa_ctl_q, ob_ctl_q;

  cspt_pkg::res_t res_q;
  logic           out_valid_q;

  logic [IW-1:0] sa_idx, sb_idx, h_idx;
  logic          h_in_range;

  // Write ports, one per table per cycle
  logic          own_we, own_vld_wd;
  logic [IW-1:0] own_idx;
  logic [CW-1:0] own_ctl_wd;
  logic          conn_we, conn_wd;
  logic [IW-1:0] conn_idx;
  logic          home_we;
  logic [CW-1:0] home_idx;
  logic [SW-1:0] home_wd;

  logic          rej;
  logic          found;
  logic [NC-1:0] home_nz;

  assign sa_idx     = IW'(req_q.slot_a - SW'(1));
  assign sb_idx     = IW'(req_q.slot_b - SW'(1));
  assign h_idx      = IW'(h_q - SW'(1));
  assign h_in_range = (h_q != '0) && (h_q <= SW'(NS));

  // Request checks
  always_comb begin
    rej = 1'b0;
    case (req_q.req_type)
      cspt_pkg::REQ_PAIR, cspt_pkg::REQ_UNPAIR: rej = !slot_ok(req_q.slot_a, slot_count_i);
      cspt_pkg::REQ_SWAP: begin
        rej = !slot_ok(req_q.slot_a, slot_count_i) || !slot_ok(req_q.slot_b, slot_count_i)
              || (req_q.slot_a == req_q.slot_b);
      end
      cspt_pkg::REQ_ARRIVAL, cspt_pkg::REQ_DEPARTURE, cspt_pkg::REQ_LOOKUP: rej = 1'b0;
      default: rej = 1'b1;
    endcase
  end

  always_comb begin
    sts_o.reject     = rej;
    sts_o.is_swap    = (req_q.req_type == cspt_pkg::REQ_SWAP);
    sts_o.has_write  = (req_q.req_type != cspt_pkg::REQ_LOOKUP);
    sts_o.two_writes = (req_q.req_type == cspt_pkg::REQ_PAIR) ||
                       (req_q.req_type == cspt_pkg::REQ_SWAP);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Table updates per phase
  always_comb begin
    own_we = 1'b0; own_idx = sa_idx; own_vld_wd = 1'b0; own_ctl_wd = req_q.ctrl_id;
    conn_we = 1'b0; conn_idx = sa_idx; conn_wd = 1'b0;
    home_we = 1'b0; home_idx = req_q.ctrl_id; home_wd = '0;
    unp_d = unp_q;
    if (cmd_i.wr_a) begin
      case (req_q.req_type)
        cspt_pkg::REQ_PAIR: begin
          // detach from the old slot
          if (h_in_range && (h_q != req_q.slot_a)) begin
            own_we = 1'b1; own_idx = h_idx; own_vld_wd = 1'b0;
            conn_we = 1'b1; conn_idx = h_idx; conn_wd = 1'b0;
          end
          // release the target slot's owner
          if (oa_vld_q) begin
            home_we = 1'b1; home_idx = oa_ctl_q; home_wd = '0;
            unp_d = unp_q | (NC'(1) << oa_ctl_q);
          end
        end
        cspt_pkg::REQ_UNPAIR: begin
          if (oa_vld_q) begin
            home_we = 1'b1; home_idx = oa_ctl_q; home_wd = '0;
            unp_d = unp_q | (NC'(1) << oa_ctl_q);
            own_we = 1'b1; own_idx = sa_idx; own_vld_wd = 1'b0;
            conn_we = 1'b1; conn_idx = sa_idx; conn_wd = 1'b0;
          end
        end
        cspt_pkg::REQ_SWAP: begin
          own_we = 1'b1; own_idx = sa_idx; own_vld_wd = ob_vld_q; own_ctl_wd = ob_ctl_q;
          conn_we = 1'b1; conn_idx = sa_idx; conn_wd = cb_q;
          if (ob_vld_q) begin
            home_we = 1'b1; home_idx = ob_ctl_q; home_wd = req_q.slot_a;
          end
        end
        cspt_pkg::REQ_ARRIVAL: begin
          if (h_in_range) begin
            conn_we = 1'b1; conn_idx = h_idx; conn_wd = 1'b1;
          end else if (h_q == '0) begin
            unp_d = unp_q | (NC'(1) << req_q.ctrl_id);
          end
        end
        cspt_pkg::REQ_DEPARTURE: begin
          if (h_in_range) begin
            conn_we = 1'b1; conn_idx = h_idx; conn_wd = 1'b0;
          end
          unp_d = unp_q & ~(NC'(1) << req_q.ctrl_id);
        end
        default: begin
          own_we = 1'b0;
        end
      endcase
    end else if (cmd_i.wr_b) begin
      if (req_q.req_type == cspt_pkg::REQ_SWAP) begin
        own_we = 1'b1; own_idx = sb_idx; own_vld_wd = oa_vld_q; own_ctl_wd = oa_ctl_q;
        conn_we = 1'b1; conn_idx = sb_idx; conn_wd = ca_q;
        if (oa_vld_q) begin
          home_we = 1'b1; home_idx = oa_ctl_q; home_wd = req_q.slot_b;
        end
      end else begin
        // pair: claim the target slot
        own_we = 1'b1; own_idx = sa_idx; own_vld_wd = 1'b1;
        own_ctl_wd = req_q.ctrl_id;
        conn_we = 1'b1; conn_idx = sa_idx; conn_wd = 1'b1;
        home_we = 1'b1; home_idx = req_q.ctrl_id; home_wd = req_q.slot_a;
        unp_d = unp_q & ~(NC'(1) << req_q.ctrl_id);
      end
    end
  end

  // Table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        own_vld_q[i] <= 1'b0;
        conn_q[i]    <= 1'b0;
      end
      for (int i = 0; i < NC; i++) begin
        home_q[i] <= '0;
      end
      unp_q <= '0;
    end else begin
      if (own_we)  own_vld_q[own_idx] <= own_vld_wd;
      if (conn_we) conn_q[conn_idx]   <= conn_wd;
      if (home_we) home_q[home_idx]   <= home_wd;
      unp_q <= unp_d;
    end
  end

  // Owner numbers carry no reset, only meaningful while valid
  always_ff @(posedge clk_i) begin
    if (own_we) own_ctl_q[own_idx] <= own_ctl_wd;
  end

  // Request capture and table reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.rd_a) begin
      h_q      <= home_q[req_q.ctrl_id];
      oa_vld_q <= own_vld_q[sa_idx];
      oa_ctl_q <= own_ctl_q[sa_idx];
      ca_q     <= conn_q[sa_idx];
    end
    if (cmd_i.rd_b) begin
      ob_vld_q <= own_vld_q[sb_idx];
      ob_ctl_q <= own_ctl_q[sb_idx];
      cb_q     <= conn_q[sb_idx];
    end
  end

  // Result register
  assign found = (req_q.req_type == cspt_pkg::REQ_LOOKUP) && slot_ok(h_q, slot_count_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q.status        <= rej;
      res_q.found         <= found;
      res_q.found_slot    <= found ? h_q : '0;
      res_q.unpaired_mask <= unp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      home_nz[i] = (home_q[i] != '0);
    end
  end

  // An unpaired controller never has a home slot
  `CSPT_ASSERT_SAME(a_unpaired_homeless, 1'b1, (unp_q & home_nz) == '0, "unpaired with home")

endmodule
